### rtl/btff_pkg.sv
// btff_pkg: types, codes and constants of the boundary tag heap allocator
// used by btff_alu and boundary_tag_first_fit_allocator; depends on nothing
package btff_pkg;

    localparam int DEF_HEAP_BYTES = 1048576;
    localparam int SIZE_W         = 21;
    localparam int REQ_W          = 21;
    localparam int OFF_W          = 20;
    localparam int CFG_W          = 17;
    localparam int CFG_IDX_W      = 1;
    localparam int GRAN_SHIFT     = 3;

    localparam logic [CFG_W-1:0] SPLIT_RESET = 17'd256;
    localparam logic [CFG_W-1:0] GROW_RESET  = 17'd4096;
    localparam logic [CFG_W-1:0] SPLIT_MIN   = 17'd8;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_MARK    = 2'd2,
        MODE_DEINIT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TOO_LARGE = 2'd1,
        STAT_NO_MEM    = 2'd2,
        STAT_NULL      = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPLIT_THRESHOLD = 1'd0,
        CFG_GROW_EXTRA      = 1'd1
    } t_cfg_idx;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] prev;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISP, ST_OFFS, ST_K_WR, ST_K_HINT,
        ST_NEED, ST_BUILD0, ST_BUILD1,
        ST_S_CHK, ST_S_RD, ST_S_ADV,
        ST_G_RND, ST_G_SUM, ST_G_END, ST_G_CMP, ST_G_OLD, ST_G_RDE, ST_G_PSUB,
        ST_G_RDP, ST_G_WOLD, ST_G_WEND,
        ST_P_RD, ST_P_HAVE, ST_P_LEFT, ST_P_THR, ST_P_KEEP, ST_P_SPLIT,
        ST_P_WNEXT, ST_P_FAR, ST_P_WFAR, ST_P_GRANT, ST_P_USE,
        ST_R_RD, ST_R_PSUB, ST_R_PRD, ST_R_NEXT, ST_R_NRD, ST_R_MSUM,
        ST_R_FAR, ST_R_FRD, ST_R_HINT,
        ST_FIN
    } t_state;

    function automatic t_hdr mk_hdr(input logic used, input logic [SIZE_W-1:0] prev,
                                    input logic [SIZE_W-1:0] size);
        t_hdr h;
        h.used = used;
        h.prev = prev;
        h.size = size;
        return h;
    endfunction

endpackage

### rtl/btff_alu.sv
// btff_alu: the one shared adder of the allocator, add or subtract with
// an unsigned less-than flag taken from the borrow; depends on btff_pkg
module btff_alu #(
    parameter int W = 22
) (
    input  btff_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W-1:0]      o_y,
    output logic              o_lt
);
    import btff_pkg::*;

    logic          is_sub;
    logic [W-1:0]  b_in;
    logic [W:0]    sum;

    assign is_sub = (i_op == ALU_SUB);
    assign b_in   = is_sub ? ~i_b : i_b;
    assign sum    = {1'b0, i_a} + {1'b0, b_in} + {{W{1'b0}}, is_sub};
    assign o_y    = sum[W-1:0];
    // carry out of a + ~b + 1 is set when a >= b
    assign o_lt   = is_sub && !sum[W];

endmodule

### rtl/boundary_tag_first_fit_allocator.sv
// Boundary tag first-fit heap allocator. One transaction in, one result out. The block keeps
// the chunk headers in an internal memory (one 43-bit header per 8 bytes of heap) and works
// each transaction with a sequencer around a single shared adder, one header read per step.
// Deinit and rejected transactions go straight to the result. An alloc builds the heap on
// first use, walks the chunk headers first-fit from the lowest free chunk, grows the heap
// when no chunk fits (or gives no-memory status when it cannot), then splits and grants;
// the walk length is set by fragmentation. The input is not ready while a transaction is in
// work; a finished result waits in the output register and only a second finished result
// waits for it. Configuration writes are taken in every cycle and should be made while idle.
// Header memory has no reset: headers are written before they are read.
module boundary_tag_first_fit_allocator #(
    parameter int HEAP_BYTES = btff_pkg::DEF_HEAP_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // request_bytes [20:0], payload_offset [40:21], zero [47:41]
    input  logic [47:0]                         i_s_axis_tdata,
    // mode [1:0]
    input  btff_pkg::t_mode                     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // granted_offset [19:0], usable_bytes [39:20]
    output logic [39:0]                         o_m_axis_tdata,
    // status [1:0]
    output btff_pkg::t_status                   o_m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [btff_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [btff_pkg::CFG_W-1:0]          i_cfg_data
);
    import btff_pkg::*;

    localparam int DEPTH = HEAP_BYTES >> GRAN_SHIFT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = ($clog2(HEAP_BYTES) + 2 > 22) ? $clog2(HEAP_BYTES) + 2 : 22;

    // header memory
    t_hdr          r_hdr_mem [DEPTH];
    t_hdr          r_q;
    logic          r_q_ok;
    t_hdr          q;
    logic          rd_en, wr_en;
    logic [PW-1:0] rd_pos, wr_pos;
    t_hdr          wr_data;

    function automatic logic slot_ok(input logic [PW-1:0] pos);
        return (pos[GRAN_SHIFT-1:0] == '0) && (pos < PW'(HEAP_BYTES));
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en && slot_ok(wr_pos)) begin
            r_hdr_mem[wr_pos[AW+GRAN_SHIFT-1:GRAN_SHIFT]] <= wr_data;
        end
        if (rd_en) begin
            r_q    <= r_hdr_mem[rd_pos[AW+GRAN_SHIFT-1:GRAN_SHIFT]];
            r_q_ok <= slot_ok(rd_pos);
        end
    end

    // headers outside the store read as zero
    assign q = r_q_ok ? r_q : '0;

    // shared adder
    t_alu_op       alu_op;
    logic [PW-1:0] alu_a, alu_b, alu_y;
    logic          alu_lt;

    btff_alu #(.W(PW)) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y),
        .o_lt (alu_lt)
    );

    // registers
    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [PW-1:0]      r_need, n_need;
    logic [PW-1:0]      r_it, n_it;
    logic [PW-1:0]      r_start, n_start;
    logic               r_seen, n_seen;
    logic [PW-1:0]      r_mem, n_mem;
    logic [PW-1:0]      r_sz, n_sz;
    logic [PW-1:0]      r_tmp, n_tmp;
    logic [PW-1:0]      r_grow, n_grow;
    logic [PW-1:0]      r_ptr, n_ptr;
    logic [SIZE_W-1:0]  r_prev, n_prev;
    logic [PW-1:0]      r_m, n_m;
    logic [PW-1:0]      r_msz, n_msz;
    logic [SIZE_W-1:0]  r_mprev, n_mprev;
    logic [OFF_W-1:0]   r_res_gr, n_res_gr;
    logic [OFF_W-1:0]   r_res_us, n_res_us;
    t_status            r_res_st, n_res_st;
    logic [PW-1:0]      r_heap_end, n_heap_end;
    logic [PW-1:0]      r_hint, n_hint;
    logic               r_ready, n_ready;
    logic               r_out_valid;
    logic [OFF_W-1:0]   r_o_gr, r_o_us;
    t_status            r_o_st;
    logic [CFG_W-1:0]   r_split, r_gext;
    logic [CFG_W-1:0]   thr_eff;
    logic               in_acc, out_load;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign thr_eff         = (r_split < SPLIT_MIN) ? SPLIT_MIN : r_split;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_req      = r_req;
        n_off      = r_off;
        n_need     = r_need;
        n_it       = r_it;
        n_start    = r_start;
        n_seen     = r_seen;
        n_mem      = r_mem;
        n_sz       = r_sz;
        n_tmp      = r_tmp;
        n_grow     = r_grow;
        n_ptr      = r_ptr;
        n_prev     = r_prev;
        n_m        = r_m;
        n_msz      = r_msz;
        n_mprev    = r_mprev;
        n_res_gr   = r_res_gr;
        n_res_us   = r_res_us;
        n_res_st   = r_res_st;
        n_heap_end = r_heap_end;
        n_hint     = r_hint;
        n_ready    = r_ready;
        rd_en      = 1'b0;
        rd_pos     = '0;
        wr_en      = 1'b0;
        wr_pos     = '0;
        wr_data    = '0;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        out_load   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_mode  = i_s_axis_tuser;
                    n_req   = i_s_axis_tdata[REQ_W-1:0];
                    n_off   = i_s_axis_tdata[REQ_W+OFF_W-1:REQ_W];
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_res_gr = '0;
                n_res_us = '0;
                n_res_st = STAT_OK;
                case (r_mode)
                    MODE_ALLOC: begin
                        alu_op = ALU_SUB;
                        alu_a  = PW'(HEAP_BYTES - 16);
                        alu_b  = PW'(r_req);
                        if (alu_lt) begin
                            n_res_st = STAT_TOO_LARGE;
                            n_state  = ST_FIN;
                        end else begin
                            n_state = ST_NEED;
                        end
                    end
                    MODE_RELEASE, MODE_MARK: begin
                        alu_op = ALU_SUB;
                        alu_a  = PW'(r_off);
                        alu_b  = r_heap_end;
                        if (r_ready && r_off != '0 && r_off[GRAN_SHIFT-1:0] == '0 && alu_lt)
                        begin
                            n_state = ST_OFFS;
                        end else begin
                            n_res_st = STAT_NULL;
                            n_state  = ST_FIN;
                        end
                    end
                    default: begin
                        n_ready    = 1'b0;
                        n_heap_end = '0;
                        n_hint     = '0;
                        n_state    = ST_FIN;
                    end
                endcase
            end
            ST_OFFS: begin
                alu_op  = ALU_SUB;
                alu_a   = PW'(r_off);
                alu_b   = PW'(8);
                n_mem   = alu_y;
                rd_en   = 1'b1;
                rd_pos  = alu_y;
                n_state = (r_mode == MODE_MARK) ? ST_K_WR : ST_R_RD;
            end
            ST_K_WR: begin
                wr_en   = 1'b1;
                wr_pos  = r_mem;
                wr_data = mk_hdr(1'b0, q.prev, q.size);
                n_state = ST_K_HINT;
            end
            ST_K_HINT: begin
                alu_op = ALU_SUB;
                alu_a  = r_mem;
                alu_b  = r_hint;
                if (alu_lt) n_hint = r_mem;
                n_state = ST_FIN;
            end
            ST_NEED: begin
                alu_a   = PW'(r_req);
                alu_b   = PW'(15);
                n_need  = {alu_y[PW-1:GRAN_SHIFT], {GRAN_SHIFT{1'b0}}};
                n_it    = r_hint;
                n_start = r_hint;
                n_seen  = 1'b0;
                n_state = r_ready ? ST_S_CHK : ST_BUILD0;
            end
            ST_BUILD0: begin
                wr_en   = 1'b1;
                wr_pos  = '0;
                wr_data = mk_hdr(1'b0, '0, r_need[SIZE_W-1:0]);
                n_state = ST_BUILD1;
            end
            ST_BUILD1: begin
                alu_a      = r_need;
                alu_b      = PW'(8);
                n_heap_end = alu_y;
                wr_en      = 1'b1;
                wr_pos     = r_need;
                wr_data    = mk_hdr(1'b0, r_need[SIZE_W-1:0], '0);
                n_hint     = '0;
                n_ready    = 1'b1;
                n_it       = '0;
                n_start    = '0;
                n_state    = ST_S_CHK;
            end
            ST_S_CHK: begin
                alu_op  = ALU_SUB;
                alu_a   = r_it;
                alu_b   = r_heap_end;
                rd_en   = 1'b1;
                rd_pos  = r_it;
                n_state = alu_lt ? ST_S_RD : ST_G_RND;
            end
            ST_S_RD: begin
                n_sz = PW'(q.size);
                if (q.size == '0) begin
                    n_state = ST_G_RND;
                end else if (q.used) begin
                    n_state = ST_S_ADV;
                end else begin
                    if (!r_seen) begin
                        n_seen = 1'b1;
                        n_hint = r_it;
                    end
                    alu_op = ALU_SUB;
                    alu_a  = PW'(q.size);
                    alu_b  = r_need;
                    if (!alu_lt) begin
                        n_mem   = r_it;
                        n_state = ST_P_RD;
                    end else begin
                        n_state = ST_S_ADV;
                    end
                end
            end
            ST_S_ADV: begin
                alu_a   = r_it;
                alu_b   = r_sz;
                n_it    = alu_y;
                n_state = ST_S_CHK;
            end
            // miss: grow the heap at the old end marker
            ST_G_RND: begin
                n_hint  = r_start;
                alu_a   = PW'(r_gext);
                alu_b   = PW'(7);
                n_tmp   = {alu_y[PW-1:GRAN_SHIFT], {GRAN_SHIFT{1'b0}}};
                n_state = ST_G_SUM;
            end
            ST_G_SUM: begin
                alu_a   = r_need;
                alu_b   = r_tmp;
                n_grow  = alu_y;
                n_state = ST_G_END;
            end
            ST_G_END: begin
                alu_a   = r_heap_end;
                alu_b   = r_grow;
                n_ptr   = alu_y;
                n_state = ST_G_CMP;
            end
            ST_G_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = PW'(HEAP_BYTES);
                alu_b  = r_ptr;
                if (alu_lt) begin
                    n_res_st = STAT_NO_MEM;
                    n_state  = ST_FIN;
                end else begin
                    n_state = ST_G_OLD;
                end
            end
            ST_G_OLD: begin
                alu_op  = ALU_SUB;
                alu_a   = r_heap_end;
                alu_b   = PW'(8);
                n_mem   = alu_y;
                rd_en   = 1'b1;
                rd_pos  = alu_y;
                n_state = ST_G_RDE;
            end
            ST_G_RDE: begin
                n_prev  = q.prev;
                n_sz    = '0;
                n_state = ST_G_WOLD;
                if (q.prev != '0) begin
                    alu_op = ALU_SUB;
                    alu_a  = r_mem;
                    alu_b  = PW'(q.prev);
                    if (!alu_lt) n_state = ST_G_PSUB;
                end
            end
            ST_G_PSUB: begin
                alu_op  = ALU_SUB;
                alu_a   = r_mem;
                alu_b   = PW'(r_prev);
                rd_en   = 1'b1;
                rd_pos  = alu_y;
                n_state = ST_G_RDP;
            end
            ST_G_RDP: begin
                n_sz    = PW'(q.size);
                n_state = ST_G_WOLD;
            end
            ST_G_WOLD: begin
                wr_en      = 1'b1;
                wr_pos     = r_mem;
                wr_data    = mk_hdr(1'b0, r_sz[SIZE_W-1:0], r_grow[SIZE_W-1:0]);
                n_heap_end = r_ptr;
                alu_a      = r_mem;
                alu_b      = r_grow;
                n_tmp      = alu_y;
                n_state    = ST_G_WEND;
            end
            ST_G_WEND: begin
                wr_en   = 1'b1;
                wr_pos  = r_tmp;
                wr_data = mk_hdr(1'b0, r_grow[SIZE_W-1:0], '0);
                n_state = ST_P_RD;
            end
            // split and grant
            ST_P_RD: begin
                rd_en   = 1'b1;
                rd_pos  = r_mem;
                n_state = ST_P_HAVE;
            end
            ST_P_HAVE: begin
                n_sz    = PW'(q.size);
                n_prev  = q.prev;
                alu_op  = ALU_SUB;
                alu_a   = PW'(q.size);
                alu_b   = r_need;
                n_state = alu_lt ? ST_P_KEEP : ST_P_LEFT;
            end
            ST_P_LEFT: begin
                alu_op  = ALU_SUB;
                alu_a   = r_sz;
                alu_b   = r_need;
                n_tmp   = alu_y;
                n_state = ST_P_THR;
            end
            ST_P_THR: begin
                alu_op  = ALU_SUB;
                alu_a   = r_tmp;
                alu_b   = PW'(thr_eff);
                n_state = alu_lt ? ST_P_KEEP : ST_P_SPLIT;
            end
            ST_P_KEEP: begin
                wr_en   = 1'b1;
                wr_pos  = r_mem;
                wr_data = mk_hdr(1'b1, r_prev, r_sz[SIZE_W-1:0]);
                n_msz   = r_sz;
                n_state = ST_P_GRANT;
            end
            ST_P_SPLIT: begin
                wr_en   = 1'b1;
                wr_pos  = r_mem;
                wr_data = mk_hdr(1'b1, r_prev, r_need[SIZE_W-1:0]);
                n_msz   = PW'(r_need[SIZE_W-1:0]);
                alu_a   = r_mem;
                alu_b   = r_need;
                n_ptr   = alu_y;
                n_state = ST_P_WNEXT;
            end
            ST_P_WNEXT: begin
                wr_en   = 1'b1;
                wr_pos  = r_ptr;
                wr_data = mk_hdr(1'b0, r_need[SIZE_W-1:0], r_tmp[SIZE_W-1:0]);
                alu_op  = ALU_SUB;
                alu_a   = r_ptr;
                alu_b   = r_hint;
                if (alu_lt) n_hint = r_ptr;
                n_state = ST_P_FAR;
            end
            ST_P_FAR: begin
                alu_a   = r_ptr;
                alu_b   = r_tmp;
                n_it    = alu_y;
                rd_en   = 1'b1;
                rd_pos  = alu_y;
                n_state = ST_P_WFAR;
            end
            ST_P_WFAR: begin
                wr_en   = 1'b1;
                wr_pos  = r_it;
                wr_data = mk_hdr(q.used, r_tmp[SIZE_W-1:0], q.size);
                n_state = ST_P_GRANT;
            end
            ST_P_GRANT: begin
                alu_a    = r_mem;
                alu_b    = PW'(8);
                n_res_gr = alu_y[OFF_W-1:0];
                n_state  = ST_P_USE;
            end
            ST_P_USE: begin
                alu_op   = ALU_SUB;
                alu_a    = r_msz;
                alu_b    = PW'(8);
                n_res_us = alu_y[OFF_W-1:0];
                n_state  = ST_FIN;
            end
            // release with merge of free neighbours
            ST_R_RD: begin
                n_prev  = q.prev;
                n_sz    = PW'(q.size);
                wr_en   = 1'b1;
                wr_pos  = r_mem;
                wr_data = mk_hdr(1'b0, q.prev, q.size);
                n_m     = r_mem;
                n_msz   = PW'(q.size);
                n_mprev = q.prev;
                n_state = ST_R_NEXT;
                if (q.prev != '0) begin
                    alu_op = ALU_SUB;
                    alu_a  = r_mem;
                    alu_b  = PW'(q.prev);
                    if (!alu_lt) n_state = ST_R_PSUB;
                end
            end
            ST_R_PSUB: begin
                alu_op  = ALU_SUB;
                alu_a   = r_mem;
                alu_b   = PW'(r_prev);
                n_ptr   = alu_y;
                rd_en   = 1'b1;
                rd_pos  = alu_y;
                n_state = ST_R_PRD;
            end
            ST_R_PRD: begin
                if (!q.used) begin
                    alu_a   = PW'(q.size);
                    alu_b   = r_sz;
                    wr_en   = 1'b1;
                    wr_pos  = r_ptr;
                    wr_data = mk_hdr(1'b0, q.prev, alu_y[SIZE_W-1:0]);
                    n_m     = r_ptr;
                    n_msz   = PW'(alu_y[SIZE_W-1:0]);
                    n_mprev = q.prev;
                end
                n_state = ST_R_NEXT;
            end
            ST_R_NEXT: begin
                alu_a   = r_mem;
                alu_b   = r_sz;
                n_ptr   = alu_y;
                rd_en   = 1'b1;
                rd_pos  = alu_y;
                n_state = ST_R_NRD;
            end
            ST_R_NRD: begin
                wr_en   = 1'b1;
                wr_pos  = r_ptr;
                wr_data = mk_hdr(q.used, r_msz[SIZE_W-1:0], q.size);
                n_tmp   = PW'(q.size);
                n_state = (!q.used && q.size != '0) ? ST_R_MSUM : ST_R_HINT;
            end
            ST_R_MSUM: begin
                alu_a   = r_msz;
                alu_b   = r_tmp;
                wr_en   = 1'b1;
                wr_pos  = r_m;
                wr_data = mk_hdr(1'b0, r_mprev, alu_y[SIZE_W-1:0]);
                n_msz   = PW'(alu_y[SIZE_W-1:0]);
                n_state = ST_R_FAR;
            end
            ST_R_FAR: begin
                alu_a   = r_ptr;
                alu_b   = r_tmp;
                n_it    = alu_y;
                rd_en   = 1'b1;
                rd_pos  = alu_y;
                n_state = ST_R_FRD;
            end
            ST_R_FRD: begin
                wr_en   = 1'b1;
                wr_pos  = r_it;
                wr_data = mk_hdr(q.used, r_msz[SIZE_W-1:0], q.size);
                n_state = ST_R_HINT;
            end
            ST_R_HINT: begin
                alu_op = ALU_SUB;
                alu_a  = r_m;
                alu_b  = r_hint;
                if (alu_lt) n_hint = r_m;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ready     <= 1'b0;
            r_heap_end  <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ready    <= n_ready;
            r_heap_end <= n_heap_end;
            r_hint     <= n_hint;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= SPLIT_RESET;
            r_gext  <= GROW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SPLIT_THRESHOLD: r_split <= i_cfg_data;
                CFG_GROW_EXTRA:      r_gext  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_req    <= n_req;
        r_off    <= n_off;
        r_need   <= n_need;
        r_it     <= n_it;
        r_start  <= n_start;
        r_seen   <= n_seen;
        r_mem    <= n_mem;
        r_sz     <= n_sz;
        r_tmp    <= n_tmp;
        r_grow   <= n_grow;
        r_ptr    <= n_ptr;
        r_prev   <= n_prev;
        r_m      <= n_m;
        r_msz    <= n_msz;
        r_mprev  <= n_mprev;
        r_res_gr <= n_res_gr;
        r_res_us <= n_res_us;
        r_res_st <= n_res_st;
        if (out_load) begin
            r_o_gr <= r_res_gr;
            r_o_us <= r_res_us;
            r_o_st <= r_res_st;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_o_us, r_o_gr};
    assign o_m_axis_tuser  = r_o_st;

    // heap length and hint stay on the 8-byte grid
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heap_end[GRAN_SHIFT-1:0] == '0) && (r_hint[GRAN_SHIFT-1:0] == '0))
        else $error("heap end or hint off the granule grid");

    a_unbuilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ready |-> (r_heap_end == '0))
        else $error("heap length set while heap not built");

    // failed transactions grant nothing
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != STAT_OK) |-> (o_m_axis_tdata == '0))
        else $error("error result carries a grant");

endmodule
